// ----- rtl/core/lbp_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_pkg: shared types and helpers of the literal byte packer
// Item structs for both channels, the write group into the result queue,
// and the mask helpers used by the packing step.
// ---------------------------------------------------------------------------
package lbp_pkg;

  localparam int WORD_BYTES = 4;
  localparam int KEEP_W     = 4;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = 3;

  localparam logic [KEEP_W-1:0] FULL_KEEP  = 4'b1111;
  localparam logic [KEEP_W-1:0] EMPTY_KEEP = 4'b0000;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [DATA_W-1:0] word_data;
    logic [KEEP_W-1:0] byte_keep;
    logic              is_length_distance;
    logic              is_final;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_data;
    logic [KEEP_W-1:0] out_keep;
    logic              out_is_length_distance;
    logic              out_is_final;
    logic              run_end;
  } out_item_t;

  // Results written into the queue in one cycle: n is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] n;
    out_item_t  first;
    out_item_t  second;
  } res_wr_t;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] count;
  } mask_info_t;

  // Count of low ones, and whether the mask is exactly that run of ones.
  function automatic mask_info_t mask_count(input logic [KEEP_W-1:0] keep);
    mask_info_t       info;
    logic [CNT_W-1:0] r;
    logic             run;
    logic [KEEP_W-1:0] ref_mask;
    r        = '0;
    run      = 1'b1;
    ref_mask = '0;
    for (int i = 0; i < KEEP_W; i++) begin
      run = run & keep[i];
      if (run) begin
        r           = r + CNT_W'(1);
        ref_mask[i] = 1'b1;
      end
    end
    info.ok    = (keep == ref_mask);
    info.count = r;
    return info;
  endfunction

  // Mask with the low count bits set.
  function automatic logic [KEEP_W-1:0] keep_of(input logic [CNT_W-1:0] count);
    logic [KEEP_W-1:0] m;
    for (int i = 0; i < KEEP_W; i++) begin
      m[i] = (i < int'(count));
    end
    return m;
  endfunction

  // Place cnt low bytes of src at byte positions at.. of dst.
  function automatic logic [DATA_W-1:0] fill_bytes(input logic [DATA_W-1:0] dst,
                                                   input logic [DATA_W-1:0] src,
                                                   input logic [CNT_W-1:0]  at,
                                                   input logic [CNT_W-1:0]  cnt);
    logic [DATA_W-1:0] moved;
    logic [DATA_W-1:0] res;
    moved = src << {at, 3'b000};
    res   = dst;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (i >= int'(at) && i < int'(at) + int'(cnt)) begin
        res[8*i +: 8] = moved[8*i +: 8];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/literal_byte_packer.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// literal_byte_packer: packs literal bytes of a stream into full words
// Partial literal words are topped up from following literal words; a
// length-distance or final word flushes the held word and passes through.
// ---------------------------------------------------------------------------
//
//  channel  handshake             payload
//  in       in_valid / in_ready   in_item  (lbp_pkg::in_item_t)
//  out      out_valid / out_ready out_item (lbp_pkg::out_item_t)
//
// One item is accepted per cycle while the input does not stall. An item is
// registered, worked on from the input register once the queue has room,
// and its results enter a four-entry result queue, from which they are
// offered oldest first. A flush writes two results at once; input stalls
// while an item waits in the input register and fewer than two queue entries
// are free. Reset empties the queue and clears the held word and packing mode.
module literal_byte_packer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lbp_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lbp_pkg::out_item_t      out_item
);
  import lbp_pkg::*;

  res_wr_t wr;
  logic    room;

  lbp_packer u_packer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .room     (room),
    .wr       (wr)
  );

  lbp_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (wr.n != 2'd0) |-> room)
    else $error("result write without queue room");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    wr.n != 2'd3)
    else $error("more than two results from one item");

  a_flush_order: assert property (@(posedge clk) disable iff (rst)
    (wr.n == 2'd2) |-> (wr.second.run_end && !wr.first.run_end))
    else $error("run end misplaced on a flush");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result queue not empty after reset");

endmodule
`default_nettype wire

// ----- rtl/core/lbp_packer.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_packer: input register, held word and packing step
// Registers each item, then in one pass decides the results it causes and
// the new held word, and writes the results into the result queue.
// ---------------------------------------------------------------------------
module lbp_packer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lbp_pkg::in_item_t in_item,
  input  wire logic             room,
  output lbp_pkg::res_wr_t      wr
);
  import lbp_pkg::*;

  logic              in_vld;
  in_item_t          in_q;
  logic              packing;
  logic [DATA_W-1:0] held_data;
  logic [KEEP_W-1:0] held_keep;

  logic              packing_next;
  logic [DATA_W-1:0] held_data_next;
  logic [KEEP_W-1:0] held_keep_next;
  logic              proc;

  mask_info_t        h_info;
  mask_info_t        c_info;
  logic [CNT_W-1:0]  need;
  logic [CNT_W-1:0]  hc;
  logic [DATA_W-1:0] fill_need;
  logic [DATA_W-1:0] fill_part;
  logic              lit;

  assign proc     = in_vld && room;
  assign in_ready = !in_vld || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld    <= 1'b0;
      packing   <= 1'b0;
      held_data <= '0;
      held_keep <= '0;
    end else begin
      if (in_ready) begin
        in_vld <= in_valid;
      end
      if (proc) begin
        packing   <= packing_next;
        held_data <= held_data_next;
        held_keep <= held_keep_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_item;
    end
  end

  always_comb begin
    h_info    = mask_count(held_keep);
    c_info    = mask_count(in_q.byte_keep);
    need      = CNT_W'(WORD_BYTES) - h_info.count;
    hc        = h_info.count + c_info.count;
    fill_need = fill_bytes(held_data, in_q.word_data, h_info.count, need);
    fill_part = fill_bytes(held_data, in_q.word_data, h_info.count, c_info.count);
    lit       = !(in_q.is_final || in_q.is_length_distance);

    packing_next   = packing;
    held_data_next = held_data;
    held_keep_next = held_keep;
    wr             = '0;
    wr.n           = proc ? 2'd0 : 2'd0;

    if (!packing) begin
      if (!lit || in_q.byte_keep == FULL_KEEP) begin
        wr.n     = 2'd1;
        wr.first = '{in_q.word_data, in_q.byte_keep, in_q.is_length_distance,
                     in_q.is_final, 1'b1};
      end else begin
        held_data_next = in_q.word_data;
        held_keep_next = in_q.byte_keep;
        packing_next   = 1'b1;
      end
    end else if (!lit) begin
      // Flush the held word first, then pass the marker word through.
      wr.n         = 2'd2;
      wr.first     = '{held_data, held_keep, 1'b0, 1'b0, 1'b0};
      wr.second    = '{in_q.word_data, in_q.byte_keep, in_q.is_length_distance,
                       in_q.is_final, 1'b1};
      packing_next = 1'b0;
    end else if (held_keep == FULL_KEEP) begin
      wr.n           = 2'd1;
      wr.first       = '{held_data, held_keep, 1'b0, 1'b0, 1'b1};
      held_data_next = in_q.word_data;
      held_keep_next = in_q.byte_keep;
    end else if (held_keep == EMPTY_KEEP) begin
      held_data_next = in_q.word_data;
      held_keep_next = in_q.byte_keep;
    end else if (h_info.ok) begin
      // A contiguous partial word: top it up from the low input bytes.
      if (in_q.byte_keep == EMPTY_KEEP) begin
        held_keep_next = held_keep;
      end else if (c_info.ok && c_info.count == need) begin
        wr.n           = 2'd1;
        wr.first       = '{fill_need, FULL_KEEP, 1'b0, 1'b0, 1'b1};
        held_data_next = fill_need;
        held_keep_next = FULL_KEEP;
        packing_next   = 1'b0;
      end else if (c_info.ok && c_info.count < need) begin
        held_data_next = fill_part;
        held_keep_next = keep_of(hc);
      end else begin
        // More bytes than needed, or an odd mask: emit and keep the rest.
        wr.n           = 2'd1;
        wr.first       = '{fill_need, FULL_KEEP, 1'b0, 1'b0, 1'b1};
        held_data_next = in_q.word_data >> {need, 3'b000};
        held_keep_next = in_q.byte_keep >> need;
      end
    end

    if (!proc) begin
      wr.n           = 2'd0;
      packing_next   = packing;
      held_data_next = held_data;
      held_keep_next = held_keep;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lbp_res_fifo.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_res_fifo: result queue
// Takes up to two result items a cycle and hands out one a cycle while the
// receiver is ready, oldest first. Room means at least two free entries.
// ---------------------------------------------------------------------------
module lbp_res_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lbp_pkg::res_wr_t  wr,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lbp_pkg::out_item_t     out_item
);
  import lbp_pkg::*;

  out_item_t            mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] count;
  logic                 pop;

  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room      = (count <= RES_CNT_W'(RES_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(wr.n);
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      count <= count + RES_CNT_W'(wr.n) - RES_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.n != 2'd0) begin
      mem[wr_ptr] <= wr.first;
    end
    if (wr.n == 2'd2) begin
      mem[wr_ptr + RES_PTR_W'(1)] <= wr.second;
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench of the literal byte packer
// A directed table of stream words covers the pass-through cases, top-up,
// overflow, holes in masks and flushes. About 1300 random words follow,
// mostly well-formed literal runs broken by pairs and final markers. Every
// result is checked field by field against a predictor of the packer, with
// random gaps on both channels and one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb;
  import lbp_pkg::*;

  localparam int N_RANDOM     = 1300;
  localparam int IDLE_LIMIT   = 1000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    in_item_t word;
    logic     thru;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  literal_byte_packer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #10 clk = ~clk;

  // Predicted packer state.
  bit                pk_packing = 1'b0;
  logic [DATA_W-1:0] pk_data    = '0;
  logic [KEEP_W-1:0] pk_keep    = '0;

  out_item_t expected_words[$];
  bit        cur_thru    = 1'b0;
  bit        calm        = 1'b0;
  bit        hold_req    = 1'b0;
  int        burst_left  = 0;
  int        errors      = 0;
  int        words_in    = 0;
  int        words_out   = 0;
  int        flushes     = 0;
  int        idle_cycles = 0;

  task automatic report(string what, longint got, longint want);
    errors++;
    if (errors <= 40) begin
      $display("ERROR %0t: %s got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  // Length of the low run of ones in a mask, or -1 when the mask has holes.
  function automatic int run_length(logic [KEEP_W-1:0] keep);
    int r;
    r = 0;
    while (r < KEEP_W && keep[r]) r++;
    return (int'(keep) == (1 << r) - 1) ? r : -1;
  endfunction

  function automatic logic [DATA_W-1:0] splice(logic [DATA_W-1:0] dst,
                                               logic [DATA_W-1:0] src,
                                               int at, int cnt);
    logic [DATA_W-1:0] res;
    res = dst;
    for (int i = 0; i < cnt; i++) begin
      if (at + i < WORD_BYTES) res[8*(at+i) +: 8] = src[8*i +: 8];
    end
    return res;
  endfunction

  // Advances the predicted state by one word and returns its result count.
  function automatic int pack_word(input in_item_t w, output out_item_t r0,
                                   output out_item_t r1);
    int n;
    int held_run;
    int need;
    int in_run;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (!pk_packing) begin
      if (w.is_final || w.is_length_distance || w.byte_keep == FULL_KEEP) begin
        r0 = {w.word_data, w.byte_keep, w.is_length_distance, w.is_final, 1'b0};
        n  = 1;
      end else begin
        pk_data    = w.word_data;
        pk_keep    = w.byte_keep;
        pk_packing = 1'b1;
      end
    end else if (w.is_final || w.is_length_distance) begin
      r0         = {pk_data, pk_keep, 3'b000};
      r1         = {w.word_data, w.byte_keep, w.is_length_distance, w.is_final, 1'b0};
      n          = 2;
      pk_packing = 1'b0;
    end else if (pk_keep == FULL_KEEP) begin
      r0      = {pk_data, pk_keep, 3'b000};
      n       = 1;
      pk_data = w.word_data;
      pk_keep = w.byte_keep;
    end else if (pk_keep == EMPTY_KEEP) begin
      pk_data = w.word_data;
      pk_keep = w.byte_keep;
    end else begin
      held_run = run_length(pk_keep);
      // A held mask with holes blocks all literals until the next flush.
      if (held_run > 0) begin
        need   = WORD_BYTES - held_run;
        in_run = run_length(w.byte_keep);
        if (w.byte_keep == EMPTY_KEEP) begin
          // Nothing to add.
        end else if (in_run == need) begin
          pk_data    = splice(pk_data, w.word_data, held_run, need);
          pk_keep    = FULL_KEEP;
          r0         = {pk_data, FULL_KEEP, 3'b000};
          n          = 1;
          pk_packing = 1'b0;
        end else if (in_run > 0 && in_run < need) begin
          pk_data = splice(pk_data, w.word_data, held_run, in_run);
          pk_keep = KEEP_W'((1 << (held_run + in_run)) - 1);
        end else begin
          r0      = {splice(pk_data, w.word_data, held_run, need), FULL_KEEP, 3'b000};
          n       = 1;
          pk_data = w.word_data >> (8 * need);
          pk_keep = w.byte_keep >> need;
        end
      end
    end
    if (n == 1) r0.run_end = 1'b1;
    if (n == 2) r1.run_end = 1'b1;
    return n;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t got;
    out_item_t want;
    out_item_t r0;
    out_item_t r1;
    int        n;
    if (!rst && out_valid && out_ready) begin
      got = out_item;
      words_out++;
      if (expected_words.size() == 0) begin
        report("result with nothing pending, out_data", got.out_data, 0);
      end else begin
        want = expected_words.pop_front();
        if (got.out_data !== want.out_data)
          report("out_data", got.out_data, want.out_data);
        if (got.out_keep !== want.out_keep)
          report("out_keep", got.out_keep, want.out_keep);
        if (got.out_is_length_distance !== want.out_is_length_distance)
          report("out_is_length_distance", got.out_is_length_distance,
                 want.out_is_length_distance);
        if (got.out_is_final !== want.out_is_final)
          report("out_is_final", got.out_is_final, want.out_is_final);
        if (got.run_end !== want.run_end)
          report("run_end", got.run_end, want.run_end);
      end
    end
    if (!rst && in_valid && in_ready) begin
      words_in++;
      n = pack_word(in_item, r0, r1);
      // Rows marked as pass-through expect the word itself back, alone.
      if (cur_thru) r0 = {in_item, 1'b1};
      if (n == 2) flushes++;
      if (n >= 1) expected_words.push_back(r0);
      if (n == 2) expected_words.push_back(r1);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: nothing accepted for %0d cycles", IDLE_LIMIT);
      $display("tb: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, none in calm stretches, one long hold-off on request.
  initial begin
    int r;
    int stall_left;
    stall_left = 0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm) begin
        r = $urandom_range(0, 99);
        if (r >= 95) stall_left = $urandom_range(10, 50);
        else if (r >= 70) stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(in_item_t w, bit thru);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (calm || burst_left > 0) gap = 0;
    else if (r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (burst_left > 0) burst_left--;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= w;
    cur_thru <= thru;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic dir_row_t dir_row(logic [DATA_W-1:0] d, logic [KEEP_W-1:0] k,
                                       logic ld, logic fin, logic thru);
    dir_row_t row;
    row.word = '{word_data: d, byte_keep: k, is_length_distance: ld, is_final: fin};
    row.thru = thru;
    return row;
  endfunction

  initial begin
    dir_row_t rows[$];
    in_item_t w;
    int       r;
    int       k;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // After reset: full literals, pairs and the final marker pass unchanged.
    rows.push_back(dir_row(32'h0000_0000, 4'hF, 1'b0, 1'b0, 1'b1));
    rows.push_back(dir_row(32'hFFFF_FFFF, 4'hF, 1'b0, 1'b0, 1'b1));
    rows.push_back(dir_row(32'hFFFF_FFFF, 4'h0, 1'b1, 1'b0, 1'b1));
    rows.push_back(dir_row(32'h0000_0000, 4'h0, 1'b0, 1'b1, 1'b1));
    // One byte held, topped up by two bytes, then filled exactly.
    rows.push_back(dir_row(32'hA0A1_A2A3, 4'h1, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'hB0B1_B2B3, 4'h3, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'hC0C1_C2C3, 4'h1, 1'b0, 1'b0, 1'b0));
    // Overflowing fills, an empty literal, and a mask with a hole.
    rows.push_back(dir_row(32'hD0D1_D2D3, 4'h7, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'hE0E1_E2E3, 4'hF, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'hF0F1_F2F3, 4'h0, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'h1234_5678, 4'h5, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'h9ABC_DEF0, 4'h3, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'hCAFE_F00D, 4'hF, 1'b1, 1'b0, 1'b0));
    // Empty word held, replaced by a full one, which a literal pushes out.
    rows.push_back(dir_row(32'h5555_5555, 4'h0, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'hAAAA_AAAA, 4'hF, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'h0F0F_0F0F, 4'h7, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'h0000_0000, 4'h0, 1'b0, 1'b1, 1'b0));
    rows.push_back(dir_row(32'h1357_9BDF, 4'h1, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'h2468_ACE0, 4'h0, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'hFEDC_BA98, 4'hE, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'h7654_3210, 4'hF, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'hDEAD_BEEF, 4'h9, 1'b1, 1'b1, 1'b0));
    // A mask with a hole held from pass-through mode blocks later literals.
    rows.push_back(dir_row(32'h8000_0001, 4'h8, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'h7FFF_FFFE, 4'hF, 1'b0, 1'b0, 1'b0));
    rows.push_back(dir_row(32'h0000_0000, 4'h0, 1'b0, 1'b1, 1'b0));
    foreach (rows[i]) send_word(rows[i].word, rows[i].thru);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      // Long receiver hold-off while the sender keeps pushing back to back.
      if (i == 400) begin
        hold_req   = 1'b1;
        burst_left = 40;
      end
      w           = '0;
      w.word_data = $urandom();
      r           = $urandom_range(0, 99);
      if (r < 58) begin
        k           = $urandom_range(0, 4);
        w.byte_keep = (k == 0) ? FULL_KEEP : KEEP_W'((1 << k) - 1);
      end else if (r < 72) begin
        w.byte_keep          = KEEP_W'($urandom_range(0, 15));
        w.is_length_distance = 1'b1;
      end else if (r < 77) begin
        w.is_final = 1'b1;
      end else if (r < 85) begin
        w.byte_keep = EMPTY_KEEP;
      end else begin
        w.byte_keep          = KEEP_W'($urandom_range(0, 15));
        w.is_length_distance = 1'($urandom_range(0, 1));
        w.is_final           = 1'($urandom_range(0, 1));
      end
      send_word(w, 1'b0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items (%0d from the directed table) and %0d results,",
             words_in, rows.size(), words_out);
    $display("with %0d two-result flushes and one %0d-cycle receiver hold-off.",
             flushes, HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
